[rtl/core/hsc_pkg.sv]
// Shared types and constants for the half/single float converter.
package hsc_pkg;

  typedef enum logic {
    ACT_H2S = 1'b0,
    ACT_S2H = 1'b1
  } action_e;

  // Operand class, decided once in the first stage.
  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_SUBNORMAL,
    CLS_NORMAL,
    CLS_SPECIAL,
    CLS_OVERFLOW,
    CLS_UNDERFLOW
  } cls_e;

  localparam logic [4:0]  HALF_EXP_MAX    = 5'h1F;
  localparam logic [9:0]  HALF_MANT_MASK  = 10'h3FF;
  localparam logic [15:0] HALF_INF        = 16'h7C00;
  localparam logic [15:0] HALF_QNAN_BIT   = 16'h0200;
  localparam logic [31:0] SINGLE_INF      = 32'h7F80_0000;
  localparam logic [7:0]  SINGLE_EXP_MAX  = SINGLE_INF[30:23];
  localparam logic [23:0] S2H_ROUND_HALF  = 24'h00_1000;
  localparam logic [23:0] SINGLE_HIDDEN   = 24'h80_0000;

  // Bias difference between binary32 and binary16 exponents.
  localparam logic [7:0]  BIAS_DIFF       = 8'd112;
  // Smallest single exponent that overflows the half range.
  localparam logic [7:0]  S2H_OVF_EXP     = 8'd143;
  // Smallest single exponent that still rounds to a half subnormal.
  localparam logic [7:0]  S2H_SUB_MIN_EXP = 8'd102;
  // Right shift for a half subnormal is this minus the single exponent.
  localparam logic [7:0]  S2H_SUB_SHIFT   = 8'd126;
  localparam logic [4:0]  HALF_EXP_TOP    = 5'd30;

  typedef struct packed {
    action_e     action;
    logic        sign;
    cls_e        cls;
    logic [7:0]  exp;
    logic [22:0] mant;
    logic [4:0]  shamt;
  } dec_t;

  typedef struct packed {
    action_e     action;
    logic        sign;
    cls_e        cls;
    logic [7:0]  exp;
    logic [23:0] frac;
  } aln_t;

endpackage

[rtl/core/hsc_if.sv]
// Stream interfaces for the converter's operand and result channels.
interface hsc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] operand_bits;

  modport source (output valid, output action, output operand_bits, input ready);
  modport sink (input valid, input action, input operand_bits, output ready);
endinterface

interface hsc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] converted_bits;

  modport source (output valid, output converted_bits, input ready);
  modport sink (input valid, input converted_bits, output ready);
endinterface

[rtl/core/hsc_decode.sv]
// First pipeline stage: field split, classification and shift amount.
module hsc_decode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic           action_i,
  input  logic [31:0]    operand_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hsc_pkg::dec_t  data_o
);
  import hsc_pkg::*;

  logic       valid_q;
  dec_t       data_d, data_q;
  logic [4:0] h_exp;
  logic [9:0] h_mant;
  logic [3:0] h_lzc;
  logic [7:0] s_exp;
  logic [7:0] s_shift;

  assign h_exp   = operand_i[14:10];
  assign h_mant  = operand_i[9:0];
  assign s_exp   = operand_i[30:23];
  assign s_shift = S2H_SUB_SHIFT - s_exp;

  // Shift that brings the leading one of a half subnormal up to the hidden bit.
  always_comb begin
    h_lzc = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h_mant[i]) begin
        h_lzc = 4'(10 - i);
      end
    end
  end

  always_comb begin
    data_d.action = action_e'(action_i);
    if (data_d.action == ACT_H2S) begin
      data_d.sign  = operand_i[15];
      data_d.exp   = {3'b000, h_exp};
      data_d.mant  = {13'd0, h_mant};
      data_d.shamt = {1'b0, h_lzc};
      if (h_exp == 5'd0) begin
        data_d.cls = (h_mant == 10'd0) ? CLS_ZERO : CLS_SUBNORMAL;
      end else if (h_exp == HALF_EXP_MAX) begin
        data_d.cls = CLS_SPECIAL;
      end else begin
        data_d.cls = CLS_NORMAL;
      end
    end else begin
      data_d.sign  = operand_i[31];
      data_d.exp   = s_exp;
      data_d.mant  = operand_i[22:0];
      data_d.shamt = s_shift[4:0];
      if (s_exp == 8'd0) begin
        data_d.cls = CLS_ZERO;
      end else if (s_exp == SINGLE_EXP_MAX) begin
        data_d.cls = CLS_SPECIAL;
      end else if (s_exp >= S2H_OVF_EXP) begin
        data_d.cls = CLS_OVERFLOW;
      end else if (s_exp <= BIAS_DIFF) begin
        data_d.cls = (s_exp < S2H_SUB_MIN_EXP) ? CLS_UNDERFLOW : CLS_SUBNORMAL;
      end else begin
        data_d.cls = CLS_NORMAL;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/hsc_align.sv]
// Second pipeline stage: renormalising shift, exponent rebias and rounding add.
module hsc_align (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hsc_pkg::dec_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output hsc_pkg::aln_t  data_o
);
  import hsc_pkg::*;

  logic        valid_q;
  aln_t        data_d, data_q;
  logic [9:0]  h_mant;
  logic [9:0]  h_norm;
  logic [24:0] sub_sum;
  logic [24:0] sub_rnd;

  assign h_mant  = data_i.mant[9:0];
  // Drop the leading one as it moves past the top of the field.
  assign h_norm  = 10'(h_mant << data_i.shamt[3:0]) & HALF_MANT_MASK;
  assign sub_sum = {1'b0, SINGLE_HIDDEN | {1'b0, data_i.mant}}
                 + (25'd1 << (data_i.shamt - 5'd1));
  assign sub_rnd = sub_sum >> data_i.shamt;

  always_comb begin
    data_d.action = data_i.action;
    data_d.sign   = data_i.sign;
    data_d.cls    = data_i.cls;
    data_d.exp    = 8'd0;
    data_d.frac   = 24'd0;
    if (data_i.action == ACT_H2S) begin
      case (data_i.cls)
        CLS_SUBNORMAL: begin
          data_d.exp  = BIAS_DIFF + 8'd1 - {4'd0, data_i.shamt[3:0]};
          data_d.frac = {1'b0, h_norm, 13'd0};
        end
        CLS_SPECIAL: begin
          data_d.exp  = SINGLE_EXP_MAX;
          data_d.frac = {1'b0, h_mant, 13'd0};
        end
        CLS_NORMAL: begin
          data_d.exp  = data_i.exp + BIAS_DIFF;
          data_d.frac = {1'b0, h_mant, 13'd0};
        end
        default: begin
          data_d.exp  = 8'd0;
          data_d.frac = 24'd0;
        end
      endcase
    end else begin
      case (data_i.cls)
        CLS_NORMAL: begin
          data_d.exp  = data_i.exp - BIAS_DIFF;
          data_d.frac = {1'b0, data_i.mant} + S2H_ROUND_HALF;
        end
        CLS_SUBNORMAL: begin
          data_d.frac = sub_rnd[23:0];
        end
        CLS_SPECIAL: begin
          data_d.frac = {23'd0, data_i.mant != 23'd0};
        end
        default: begin
          data_d.frac = 24'd0;
        end
      endcase
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/hsc_pack.sv]
// Third pipeline stage: rounding carry, special values and result packing.
module hsc_pack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  hsc_pkg::aln_t  data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [31:0]    converted_bits_o
);
  import hsc_pkg::*;

  logic        valid_q;
  logic [31:0] result_d, result_q;
  action_e     action_q;
  logic [15:0] half;
  logic [4:0]  h_exp;

  assign h_exp = data_i.exp[4:0];

  always_comb begin
    case (data_i.cls)
      CLS_NORMAL: begin
        if (data_i.frac[23]) begin
          // Carry out of the mantissa: step to the next binade.
          half = (h_exp == HALF_EXP_TOP) ? {data_i.sign, HALF_INF[14:0]}
                                         : {data_i.sign, h_exp + 5'd1, 10'd0};
        end else begin
          half = {data_i.sign, h_exp, data_i.frac[22:13]};
        end
      end
      CLS_SUBNORMAL: half = {data_i.sign, 4'd0, data_i.frac[10:0]};
      CLS_SPECIAL: begin
        half = {data_i.sign, HALF_INF[14:0]
                | (data_i.frac[0] ? HALF_QNAN_BIT[14:0] : 15'd0)};
      end
      CLS_OVERFLOW: half = {data_i.sign, HALF_INF[14:0]};
      default:      half = {data_i.sign, 15'd0};
    endcase
  end

  assign result_d = (data_i.action == ACT_H2S)
                  ? {data_i.sign, data_i.exp, data_i.frac[22:0]}
                  : {16'd0, half};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_d;
      action_q <= data_i.action;
    end
  end

  assign valid_o          = valid_q;
  assign converted_bits_o = result_q;

  a_half_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && action_q == ACT_S2H |-> result_q[31:16] == 16'd0)
    else $error("half result has upper bits set");

  a_single_no_subnormal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && action_q == ACT_H2S |->
      !(result_q[30:23] == 8'd0 && result_q[22:0] != 23'd0))
    else $error("widened half produced a single subnormal");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !ready_i |=> valid_q && $stable(result_q) && $stable(action_q))
    else $error("output stage lost or changed a stalled transaction");

endmodule

[rtl/core/half_single_float_converter.sv]
// Top level of the half/single float converter: three-stage pipeline.
//
// Converts one IEEE 754 bit pattern per transaction. On the in_i channel,
// action = 0 widens the half in operand_bits[15:0] to single, action = 1
// narrows the single in operand_bits to half (round half away from zero,
// single subnormals flushed to zero, NaN made quiet with payload dropped).
// The out_o channel returns converted_bits; a half result sits in bits 15..0
// with bits 31..16 zero.
// A transaction accepted on in_i passes the decode, align and pack
// registers before it is offered on out_o. Throughput: one transaction
// per cycle while out_o is not stalled, set by the three stage registers
// each taking a new item as the next stage frees. When out_o is stalled,
// each full stage holds while the next is full; in_i.ready falls only
// once all three stages are full, so nothing is lost or repeated.
// Reset clears the stage valid bits; the block then accepts at once.
module half_single_float_converter (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsc_in_if.sink    in_i,
  hsc_out_if.source out_o
);
  import hsc_pkg::*;

  logic dec_valid, dec_ready;
  logic aln_valid, aln_ready;
  dec_t dec_data;
  aln_t aln_data;

  hsc_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_i.valid),
    .ready_o   (in_i.ready),
    .action_i  (in_i.action),
    .operand_i (in_i.operand_bits),
    .valid_o   (dec_valid),
    .ready_i   (dec_ready),
    .data_o    (dec_data)
  );

  hsc_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .data_i  (dec_data),
    .valid_o (aln_valid),
    .ready_i (aln_ready),
    .data_o  (aln_data)
  );

  hsc_pack u_pack (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (aln_valid),
    .ready_o          (aln_ready),
    .data_i           (aln_data),
    .valid_o          (out_o.valid),
    .ready_i          (out_o.ready),
    .converted_bits_o (out_o.converted_bits)
  );

endmodule

[verif/half_single_float_converter_tb.sv]
// Self-checking testbench for the half/single float converter.
module half_single_float_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  typedef struct packed {
    action_e     act;
    logic [31:0] bits;
  } conv_req_t;

  localparam int RANDOM_REQS  = 800;
  localparam int MAX_REPORTED = 10;

  logic clk_i;
  logic rst_ni;

  hsc_in_if  in_ch ();
  hsc_out_if out_ch ();

  half_single_float_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  conv_req_t   pending_reqs[$];
  logic [31:0] expected_bits[$];
  int          mismatches;
  int          errors;

  conv_req_t   next_req;
  int          burst_left;
  int          gap_left;
  logic [15:0] stall_pat;
  logic [3:0]  stall_pos;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Half to single is exact; a subnormal is renormalised by its leading zeros.
  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] mant;
    int         lz;
    ex   = h[14:10];
    mant = h[9:0];
    if (ex == 5'd0) begin
      if (mant == 10'd0) return {h[15], 31'h0};
      lz = 1;
      while (!mant[10 - lz]) lz++;
      mant = mant << lz;
      return {h[15], 8'(113 - lz), mant, 13'h0};
    end
    if (ex == HALF_EXP_MAX) return {h[15], SINGLE_EXP_MAX, mant, 13'h0};
    return {h[15], 8'(ex) + BIAS_DIFF, mant, 13'h0};
  endfunction

  // Single to half: round half away from zero, flush single subnormals.
  function automatic logic [15:0] narrow_single(logic [31:0] f);
    logic [15:0] sgn;
    int unsigned mant;
    int          ex;
    int unsigned sh;
    sgn  = {f[31], 15'h0};
    mant = f[22:0];
    ex   = int'(f[30:23]) - 112;
    if (f[30:23] == 8'h00) return sgn;
    if (f[30:23] == SINGLE_EXP_MAX)
      return sgn | HALF_INF | ((mant != 0) ? HALF_QNAN_BIT : 16'h0);
    if (ex >= 31) return sgn | HALF_INF;
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      mant = mant | SINGLE_HIDDEN;
      sh   = 14 - ex;
      mant = (mant + (32'd1 << (sh - 1))) >> sh;
      return sgn | mant[15:0];
    end
    mant = mant + S2H_ROUND_HALF;
    if ((mant & SINGLE_HIDDEN) != 0) begin
      mant = 0;
      ex++;
      if (ex >= 31) return sgn | HALF_INF;
    end
    return sgn | 16'(ex << 10) | 16'(mant >> 13);
  endfunction

  function automatic logic [31:0] convert_expected(action_e act, logic [31:0] bits);
    if (act == ACT_H2S) return widen_half(bits[15:0]);
    return {16'h0, narrow_single(bits)};
  endfunction

  task automatic add_req(action_e act, logic [31:0] bits);
    conv_req_t r;
    r.act  = act;
    r.bits = bits;
    pending_reqs.push_back(r);
  endtask

  // Sender: bursts of random length separated by random gaps, often none.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid        <= 1'b0;
      in_ch.action       <= ACT_H2S;
      in_ch.operand_bits <= 32'h0;
      burst_left         <= 0;
      gap_left           <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_bits.push_back(convert_expected(action_e'(in_ch.action),
                                                 in_ch.operand_bits));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (pending_reqs.size() != 0) begin
          next_req            = pending_reqs.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.action       <= next_req.act;
          in_ch.operand_bits <= next_req.bits;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: walk a 16-bit ready pattern, refreshed on every wrap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_pat    <= 16'hFFFF;
      stall_pos    <= 4'd0;
    end else begin
      out_ch.ready <= stall_pat[stall_pos];
      stall_pos    <= stall_pos + 4'd1;
      if (stall_pos == 4'd15)
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_bits.size() == 0) begin
        errors++;
        $display("%0t: result 0x%08h with no transaction outstanding",
                 $realtime, out_ch.converted_bits);
      end else if (out_ch.converted_bits !== expected_bits[0]) begin
        errors++;
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: converted_bits expected 0x%08h got 0x%08h",
                   $realtime, expected_bits[0], out_ch.converted_bits);
        void'(expected_bits.pop_front());
      end else begin
        void'(expected_bits.pop_front());
      end
    end
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0] bits;
    logic [22:0] mant;
    mismatches         = 0;
    errors             = 0;
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_H2S;
    in_ch.operand_bits = 32'h0;
    out_ch.ready       = 1'b0;

    // Half operands: zeros, subnormals, largest normal, an infinity, NaN,
    // junk in the ignored upper half.
    add_req(ACT_H2S, 32'h0000_0000);
    add_req(ACT_H2S, 32'h0000_8000);
    add_req(ACT_H2S, 32'h0000_0001);
    add_req(ACT_H2S, 32'h0000_83FF);
    add_req(ACT_H2S, 32'h0000_7BFF);
    add_req(ACT_H2S, 32'h0000_FC00);
    add_req(ACT_H2S, 32'h0000_7E01);
    add_req(ACT_H2S, 32'hFFFF_3C00);
    // Single operands: zeros, subnormals, infinities, NaNs, overflow,
    // underflow edges, rounding carries and a tie.
    add_req(ACT_S2H, 32'h0000_0000);
    add_req(ACT_S2H, 32'h8000_0000);
    add_req(ACT_S2H, 32'h0000_0001);
    add_req(ACT_S2H, 32'h807F_FFFF);
    add_req(ACT_S2H, 32'h7F80_0000);
    add_req(ACT_S2H, 32'hFF80_0000);
    add_req(ACT_S2H, 32'h7F80_0001);
    add_req(ACT_S2H, 32'hFFC1_2345);
    add_req(ACT_S2H, 32'h4780_0000);
    add_req(ACT_S2H, 32'hFF7F_FFFF);
    add_req(ACT_S2H, 32'h32FF_FFFF);
    add_req(ACT_S2H, 32'h3300_0000);
    add_req(ACT_S2H, 32'h387F_F000);
    add_req(ACT_S2H, 32'hC77F_F000);
    add_req(ACT_S2H, 32'h3FFF_F000);
    add_req(ACT_S2H, 32'h3F80_1000);
    add_req(ACT_S2H, 32'h3F80_0000);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      bits = $urandom;
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: bits[14:10] = 5'd0;
          1: bits[14:10] = HALF_EXP_MAX;
          default: ;
        endcase
        add_req(ACT_H2S, bits);
      end else begin
        mant = 23'($urandom);
        case ($urandom_range(0, 7))
          2, 3, 4: bits[30:23] = 8'($urandom_range(100, 145));
          5: begin
            // steer towards ties and rounding carries
            bits[30:23] = 8'($urandom_range(100, 143));
            if ($urandom_range(0, 1) == 0) mant[12:0] = 13'h1000;
            else mant[22:12] = 11'h7FF;
            bits[22:0] = mant;
          end
          6: begin
            bits[30:23] = ($urandom_range(0, 1) == 0) ? 8'h00 : SINGLE_EXP_MAX;
            if ($urandom_range(0, 3) == 0) bits[22:0] = 23'h0;
          end
          7: bits[30:23] = 8'($urandom_range(0, 255));
          default: ;
        endcase
        add_req(ACT_S2H, bits);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_ch.valid || expected_bits.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (expected_bits.size() != 0) begin
      errors += expected_bits.size();
      $display("%0d results never arrived", expected_bits.size());
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
